>>> sv/sisbw_pkg.sv
// Shared types, constants and helpers for the stack insertion sort by width unit.
package sisbw_pkg;

	localparam int STORE_DEPTH_DEF = 32;
	localparam int WIDTH_W = 16;
	localparam int HEIGHT_W = 15;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

	typedef struct packed {
		logic load;
		logic shift_out;
	} cmd_t;

	typedef struct packed {
		logic count_one;
	} status_t;

	function automatic logic [HEIGHT_W-1:0] abs_height(input logic signed [15:0] h);
		logic [15:0] neg;
		neg = 16'(-h);
		if (!h[15]) begin
			return h[HEIGHT_W-1:0];
		end else if (h == 16'sh8000) begin
			return {HEIGHT_W{1'b1}};
		end else begin
			return neg[HEIGHT_W-1:0];
		end
	endfunction

endpackage

>>> sv/stack_insertion_sort_by_width_unit.sv
// Top level: stable insertion sort of cubes by width, absolute heights on output.
// Loading: one item per cycle while busy is low; each item is inserted in place.
// Emission: after the item marked last, results start on the next cycle, one per cycle, one for
// each stored cube (1 to STORE_DEPTH), taken from the head of the cell chain as it shifts out.
// busy is high during emission; the receiver cannot stall. Reset (arst_n low) empties the store
// and clears the drop flag; stored entries need no clearing.
module stack_insertion_sort_by_width_unit
	import sisbw_pkg::*;
#(
	parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [WIDTH_W-1:0]  cube_width,
	input  logic signed [15:0]  cube_height,
	input  logic                last_cube,
	output logic                result_valid,
	output logic [WIDTH_W-1:0]  sorted_width,
	output logic [HEIGHT_W-1:0] sorted_height,
	output logic                last_sorted,
	output logic                overflow
);

	cmd_t    cmd;
	status_t status;

	sisbw_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.last_cube    (last_cube),
		.status       (status),
		.cmd          (cmd),
		.busy         (busy),
		.result_valid (result_valid),
		.last_sorted  (last_sorted)
	);

	sisbw_dpath #(
		.DEPTH (STORE_DEPTH)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cube_width  (cube_width),
		.cube_height (cube_height),
		.status      (status),
		.head_width  (sorted_width),
		.head_height (sorted_height),
		.drop        (overflow)
	);

endmodule

>>> sv/sisbw_ctrl.sv
// Controller state machine: load items, then emit the sorted set.
module sisbw_ctrl
	import sisbw_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  logic    last_cube,
	input  status_t status,
	output cmd_t    cmd,
	output logic    busy,
	output logic    result_valid,
	output logic    last_sorted
);

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd.load = 1'b0;
		cmd.shift_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (last_cube) begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_EMIT: begin
				cmd.shift_out = 1'b1;
				if (status.count_one) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q == ST_EMIT);
	assign result_valid = (state_q == ST_EMIT);
	assign last_sorted = (state_q == ST_EMIT) && status.count_one;

endmodule

>>> sv/sisbw_dpath.sv
// Datapath: sorted insertion cell chain, fill count and drop flag.
module sisbw_dpath
	import sisbw_pkg::*;
#(
	parameter int DEPTH = STORE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	input  logic [WIDTH_W-1:0]  cube_width,
	input  logic signed [15:0]  cube_height,
	output status_t             status,
	output logic [WIDTH_W-1:0]  head_width,
	output logic [HEIGHT_W-1:0] head_height,
	output logic                drop
);

	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH_W-1:0]  width_q  [DEPTH];
	logic [HEIGHT_W-1:0] height_q [DEPTH];
	logic [CW-1:0]       count_q;
	logic                drop_q;
	logic [DEPTH-1:0]    gt;
	logic                full;
	logic [HEIGHT_W-1:0] new_height;

	assign full = (count_q == CW'(DEPTH));
	assign new_height = abs_height(cube_height);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic take;
		logic from_prev;

		assign gt[i] = (CW'(i) < count_q) && (width_q[i] > cube_width);
		assign take = gt[i] || (CW'(i) == count_q);
		if (i == 0) begin : g_first
			assign from_prev = 1'b0;
		end else begin : g_rest
			assign from_prev = gt[i-1];
		end

		always_ff @(posedge clk) begin
			if (cmd.load && !full && take) begin
				if (from_prev) begin
					width_q[i]  <= width_q[(i > 0) ? i-1 : 0];
					height_q[i] <= height_q[(i > 0) ? i-1 : 0];
				end else begin
					width_q[i]  <= cube_width;
					height_q[i] <= new_height;
				end
			end else if (cmd.shift_out && (i < DEPTH - 1)) begin
				width_q[i]  <= width_q[(i < DEPTH - 1) ? i+1 : i];
				height_q[i] <= height_q[(i < DEPTH - 1) ? i+1 : i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			drop_q  <= 1'b0;
		end else if (cmd.load) begin
			if (full) begin
				drop_q <= 1'b1;
			end else begin
				count_q <= count_q + CW'(1);
			end
		end else if (cmd.shift_out) begin
			count_q <= count_q - CW'(1);
			if (count_q == CW'(1)) begin
				drop_q <= 1'b0;
			end
		end
	end

	assign status.count_one = (count_q == CW'(1));
	assign head_width  = width_q[0];
	assign head_height = height_q[0];
	assign drop        = drop_q;

endmodule

>>> sv/sisbw_checker.sv
// Port-level checker for the sort unit and its bind to the top level.
module sisbw_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic last_cube,
	input logic result_valid,
	input logic last_sorted
);

	a_valid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy)
		else $error("result strobe outside busy");

	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !last_cube |=> !result_valid)
		else $error("result after a non-last item");

	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && last_cube |=> result_valid)
		else $error("no result after last item");

	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last_sorted |=> !busy)
		else $error("busy after final result");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last_sorted |=> result_valid)
		else $error("gap inside a result run");

endmodule

bind stack_insertion_sort_by_width_unit sisbw_checker u_sisbw_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.last_cube    (last_cube),
	.result_valid (result_valid),
	.last_sorted  (last_sorted)
);

>>> test/stack_insertion_sort_by_width_unit_tb.sv
// Testbench for the stack insertion sort by width unit: directed and randomized cube sets checked
// against a local insertion sort.
`timescale 1ns / 100ps

module stack_insertion_sort_by_width_unit_tb;
	import sisbw_pkg::*;

	localparam int DEPTH = STORE_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 300000;
	localparam int SETTLE_CYCLES = 4;

	typedef struct {
		logic [WIDTH_W-1:0] width;
		logic signed [15:0] height;
		logic               last;
		logic               settle;
	} cube_item_t;

	typedef struct {
		logic [WIDTH_W-1:0]  width;
		logic [HEIGHT_W-1:0] height;
		logic                last;
		logic                dropped;
	} sorted_cube_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic [WIDTH_W-1:0]  cube_width = '0;
	logic signed [15:0]  cube_height = '0;
	logic                last_cube = 1'b0;
	logic                result_valid;
	logic [WIDTH_W-1:0]  sorted_width;
	logic [HEIGHT_W-1:0] sorted_height;
	logic                last_sorted;
	logic                overflow;

	cube_item_t   cubes_pending[$];
	sorted_cube_t sorted_due[$];
	cube_item_t   next_cube;

	logic [WIDTH_W-1:0]  shelf_width [DEPTH];
	logic [HEIGHT_W-1:0] shelf_height [DEPTH];
	int                  shelf_count = 0;
	logic                shelf_dropped = 1'b0;

	int accepted = 0;
	int quiet_cycles = 0;
	int errors = 0;
	int cycles = 0;

	stack_insertion_sort_by_width_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cube_width   (cube_width),
		.cube_height  (cube_height),
		.last_cube    (last_cube),
		.result_valid (result_valid),
		.sorted_width (sorted_width),
		.sorted_height(sorted_height),
		.last_sorted  (last_sorted),
		.overflow     (overflow)
	);

	always #5 clk = ~clk;

	function automatic logic [HEIGHT_W-1:0] magnitude15(input logic signed [15:0] h);
		logic signed [15:0] m;
		if (h == 16'sh8000) begin
			return {HEIGHT_W{1'b1}};
		end
		m = (h < 0) ? -h : h;
		return m[HEIGHT_W-1:0];
	endfunction

	task automatic insert_cube(input logic [WIDTH_W-1:0] w, input logic signed [15:0] h,
			input logic last);
		int pos;
		sorted_cube_t s;
		if (shelf_count >= DEPTH) begin
			shelf_dropped = 1'b1;
		end else begin
			pos = shelf_count;
			while (pos > 0 && shelf_width[pos-1] > w) begin
				shelf_width[pos] = shelf_width[pos-1];
				shelf_height[pos] = shelf_height[pos-1];
				pos--;
			end
			shelf_width[pos] = w;
			shelf_height[pos] = magnitude15(h);
			shelf_count++;
		end
		if (last) begin
			for (int k = 0; k < shelf_count; k++) begin
				s.width = shelf_width[k];
				s.height = shelf_height[k];
				s.last = (k == shelf_count - 1);
				s.dropped = shelf_dropped;
				sorted_due.push_back(s);
			end
			shelf_count = 0;
			shelf_dropped = 1'b0;
		end
	endtask

	task automatic add_cube(input logic [WIDTH_W-1:0] w, input logic signed [15:0] h,
			input logic last, input logic settle);
		cube_item_t c;
		c.width = w;
		c.height = h;
		c.last = last;
		c.settle = settle;
		cubes_pending.push_back(c);
	endtask

	function automatic logic [WIDTH_W-1:0] pick_width();
		case ($urandom_range(0, 3))
			0: return WIDTH_W'($urandom_range(0, 7));
			1: return $urandom_range(0, 1) ? {WIDTH_W{1'b1}} : '0;
			default: return WIDTH_W'($urandom);
		endcase
	endfunction

	function automatic logic signed [15:0] pick_height();
		case ($urandom_range(0, 5))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'(int'($urandom_range(0, 2)) - 1);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			cube_width <= '0;
			cube_height <= '0;
			last_cube <= 1'b0;
			quiet_cycles <= 0;
		end else begin
			if (start && !busy) begin
				insert_cube(cube_width, cube_height, last_cube);
				accepted++;
			end
			quiet_cycles <= (sorted_due.size() == 0 && !busy && !(start && !busy)) ?
				quiet_cycles + 1 : 0;
			if (!start || !busy) begin
				if (cubes_pending.size() == 0) begin
					start <= 1'b0;
				end else if (cubes_pending[0].settle && (sorted_due.size() != 0 || busy ||
						quiet_cycles < SETTLE_CYCLES)) begin
					start <= 1'b0;
				end else if (!(accepted >= 70 && accepted < 110) &&
						$urandom_range(0, 99) < 21) begin
					start <= 1'b0;
				end else begin
					next_cube = cubes_pending.pop_front();
					cube_width <= next_cube.width;
					cube_height <= next_cube.height;
					last_cube <= next_cube.last;
					start <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		sorted_cube_t want;
		if (arst_n && result_valid) begin
			if (sorted_due.size() == 0) begin
				$display("%0t: unexpected item, expected none actual width %0h height %0h",
					$time, sorted_width, sorted_height);
				errors++;
			end else begin
				want = sorted_due.pop_front();
				check_field("sorted_width", 32'(want.width), 32'(sorted_width));
				check_field("sorted_height", 32'(want.height), 32'(sorted_height));
				check_field("last_sorted", 32'(want.last), 32'(last_sorted));
				check_field("overflow", 32'(want.dropped), 32'(overflow));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		int total;
		int len;
		int sets;
		logic settle;

		add_cube(16'd3, 16'sd5, 1'b0, 1'b0);
		add_cube(16'd0, 16'sh8000, 1'b0, 1'b0);
		add_cube(16'hffff, 16'sh7fff, 1'b0, 1'b0);
		add_cube(16'd3, -16'sd1, 1'b0, 1'b0);
		add_cube(16'd0, 16'sd0, 1'b0, 1'b0);
		add_cube(16'h8000, -16'sd32767, 1'b0, 1'b0);
		add_cube(16'd3, 16'sd1, 1'b0, 1'b0);
		add_cube(16'hffff, -16'sd2, 1'b0, 1'b0);
		add_cube(16'haaaa, 16'sh2aaa, 1'b0, 1'b0);
		add_cube(16'd3, 16'sh5555, 1'b1, 1'b0);
		add_cube(16'h5555, 16'shaaaa, 1'b1, 1'b1);
		add_cube(16'd7, 16'sd100, 1'b0, 1'b0);
		add_cube(16'd7, -16'sd100, 1'b0, 1'b0);
		add_cube(16'd6, 16'sh8000, 1'b1, 1'b0);

		total = cubes_pending.size();
		sets = 0;
		while (total < 160) begin
			if (sets == 0) begin
				len = DEPTH + 1;
			end else if (sets == 1) begin
				len = DEPTH + 4;
			end else if ($urandom_range(0, 9) == 0) begin
				len = $urandom_range(DEPTH - 2, DEPTH + 4);
			end else begin
				len = $urandom_range(1, 10);
			end
			settle = (sets == 0) || ($urandom_range(0, 7) == 0);
			for (int i = 0; i < len; i++) begin
				add_cube(pick_width(), pick_height(), i == len - 1, settle && i == 0);
			end
			total += len;
			sets++;
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		do @(negedge clk);
		while (cubes_pending.size() != 0 || start || sorted_due.size() != 0);
		repeat (40) @(negedge clk);

		if (errors == 0 && sorted_due.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

>>> stack_insertion_sort_by_width_unit.f
sv/sisbw_pkg.sv
sv/sisbw_ctrl.sv
sv/sisbw_dpath.sv
sv/stack_insertion_sort_by_width_unit.sv
sv/sisbw_checker.sv
test/stack_insertion_sort_by_width_unit_tb.sv
